>>> rtl/core/voxel_raycast_grid_update_defines.svh
// Assertion macros shared by the voxel ray-cast grid RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef VOXEL_RAYCAST_GRID_UPDATE_DEFINES_SVH
`define VOXEL_RAYCAST_GRID_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
`define VRGU_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VRGU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VRGU_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define VRGU_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/core/vrgu_pkg.sv
// Shared types, constants and helper functions for the voxel ray-cast grid.
// No dependencies; imported by the front, back and top-level modules.
package vrgu_pkg;

  localparam int CS      = 8;   // signed walk coordinate, covers -1 .. 64
  localparam int DW      = 6;   // absolute delta per axis, at most 63
  localparam int KW      = 7;   // steps taken per axis, at most 64
  localparam int MW      = 15;  // squared distances
  localparam int MAX_RES = 40;  // result cap per cast
  localparam int NW      = 6;   // result counter

  localparam logic [1:0] CELL_UNKNOWN = 2'd0;
  localparam logic [1:0] CELL_FREE    = 2'd1;
  localparam logic [1:0] CELL_OCC     = 2'd2;

  localparam logic [1:0] REG_SENSOR_X = 2'd0;
  localparam logic [1:0] REG_SENSOR_Y = 2'd1;
  localparam logic [1:0] REG_SENSOR_Z = 2'd2;

  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_REJECT = 2'd1,
    OP_CAST   = 2'd2
  } op_t;

  typedef logic signed [CS-1:0] coord_t;

  typedef struct packed {
    op_t             op;
    coord_t          sx;
    coord_t          sy;
    coord_t          sz;
    coord_t          ex;
    coord_t          ey;
    coord_t          ez;
    logic [2:0]      neg;   // step direction per axis, bit 0 is x
    logic [DW-1:0]   ax;
    logic [DW-1:0]   ay;
    logic [DW-1:0]   az;
    logic [MW-1:0]   maxd;
  } item_t;

  typedef struct packed {
    logic       freed;
    logic [3:0] x;
    logic [3:0] y;
    logic [2:0] z;
    logic       oor;
  } result_t;

  // True when the crossing (ka+1)/aa comes strictly before (kb+1)/ab.
  // A zero delta never crosses.
  function automatic logic earlier(input logic [KW-1:0] ka, input logic [DW-1:0] aa,
                                   input logic [KW-1:0] kb, input logic [DW-1:0] ab);
    logic [KW+DW:0] pa;
    logic [KW+DW:0] pb;
    logic           res;
    pa = (KW+DW+1)'({1'b0, ka} + (KW+1)'(1)) * (KW+DW+1)'(ab);
    pb = (KW+DW+1)'({1'b0, kb} + (KW+1)'(1)) * (KW+DW+1)'(aa);
    priority if (aa == '0) begin
      res = 1'b0;
    end else if (ab == '0) begin
      res = 1'b1;
    end else begin
      res = pa < pb;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/vrgu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vrgu_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/vrgu_fifo.sv
// Small request queue between the front and back parts of the grid block.
// No dependencies.
module vrgu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/vrgu_front.sv
// Front part: sensor registers, input acceptance and request classification.
// Depends on vrgu_pkg.
module vrgu_front #(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [9:0]     cfg_data,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,   // end_x, end_y, end_z, zero fill
  input  logic           s_tuser,   // kind
  input  logic           clearing,
  input  logic           q_full,
  output logic           q_push,
  output vrgu_pkg::item_t q_item
);
  import vrgu_pkg::*;

  logic signed [9:0]  sens_x;
  logic signed [9:0]  sens_y;
  logic signed [9:0]  sens_z;
  logic signed [9:0]  end_x;
  logic signed [9:0]  end_y;
  logic signed [9:0]  end_z;
  logic signed [10:0] dx;
  logic signed [10:0] dy;
  logic signed [10:0] dz;
  logic [10:0]        mx;
  logic [10:0]        my;
  logic [10:0]        mz;
  logic               s_in;
  logic               e_in;

  function automatic logic in_grid(input logic signed [9:0] x, input logic signed [9:0] y,
                                   input logic signed [9:0] z);
    return (x >= 0) && (int'(x) < GRID_X) && (y >= 0) && (int'(y) < GRID_Y) &&
           (z >= 0) && (int'(z) < GRID_Z);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_x <= '0;
      sens_y <= '0;
      sens_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SENSOR_X: sens_x <= cfg_data;
        REG_SENSOR_Y: sens_y <= cfg_data;
        REG_SENSOR_Z: sens_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign end_x = s_tdata[9:0];
  assign end_y = s_tdata[19:10];
  assign end_z = s_tdata[29:20];

  assign s_in = in_grid(sens_x, sens_y, sens_z);
  assign e_in = in_grid(end_x, end_y, end_z);

  assign dx = 11'(end_x) - 11'(sens_x);
  assign dy = 11'(end_y) - 11'(sens_y);
  assign dz = 11'(end_z) - 11'(sens_z);
  assign mx = dx[10] ? 11'(-dx) : 11'(dx);
  assign my = dy[10] ? 11'(-dy) : 11'(dy);
  assign mz = dz[10] ? 11'(-dz) : 11'(dz);

  always_comb begin
    q_item.sx   = sens_x[CS-1:0];
    q_item.sy   = sens_y[CS-1:0];
    q_item.sz   = sens_z[CS-1:0];
    q_item.ex   = end_x[CS-1:0];
    q_item.ey   = end_y[CS-1:0];
    q_item.ez   = end_z[CS-1:0];
    q_item.neg  = {dz[10], dy[10], dx[10]};
    q_item.ax   = mx[DW-1:0];
    q_item.ay   = my[DW-1:0];
    q_item.az   = mz[DW-1:0];
    q_item.maxd = MW'(mx[DW-1:0]) * MW'(mx[DW-1:0]) + MW'(my[DW-1:0]) * MW'(my[DW-1:0]) +
                  MW'(mz[DW-1:0]) * MW'(mz[DW-1:0]);
    if (!s_tuser) begin
      q_item.op = e_in ? OP_MARK : OP_REJECT;
    end else begin
      q_item.op = (s_in && e_in) ? OP_CAST : OP_REJECT;
    end
  end

  assign s_tready = !q_full && !clearing;
  assign q_push   = s_tvalid && s_tready;

endmodule

>>> rtl/core/vrgu_back.sv
// Back part: grid memory, clearing pass, ray walker and result output register.
// Depends on vrgu_pkg, vrgu_ram and the assertion macro header.
`include "voxel_raycast_grid_update_defines.svh"
module vrgu_back #(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  output logic            q_pop,
  input  vrgu_pkg::item_t q_item,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,   // cell_x, cell_y, cell_z, zero fill
  output logic [1:0]      m_tuser,   // freed_valid, out_of_range
  output logic            m_tlast,
  output logic            clearing
);
  import vrgu_pkg::*;

  localparam int NCELL = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(NCELL);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t        state;
  item_t         it;
  coord_t        cx;
  coord_t        cy;
  coord_t        cz;
  logic [KW-1:0] kx;
  logic [KW-1:0] ky;
  logic [KW-1:0] kz;
  logic [NW-1:0] nres;
  logic [AW-1:0] clr_addr;
  logic          at_end;
  logic          far;
  logic [2:0]    step;
  logic          pend_v;
  result_t       pend;
  logic          out_v;
  result_t       out_r;
  logic          out_last;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [1:0]    mem_rdata;

  logic          ofree;
  logic          occ;
  logic          adv;
  logic          cur_in;
  logic          load_out;
  result_t       out_d;
  logic          last_d;
  logic [MW-1:0] sq_dist;
  logic          e_xy;
  logic          e_xz;
  logic          e_yz;
  logic [2:0]    step_c;

  function automatic logic [AW-1:0] cell_idx(input coord_t x, input coord_t y, input coord_t z);
    return AW'(int'(x) + int'(y) * GRID_X + int'(z) * GRID_X * GRID_Y);
  endfunction

  vrgu_ram #(
    .WIDTH(2),
    .DEPTH(NCELL)
  ) u_cells (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign clearing  = state == S_CLEAR;
  assign ofree     = !out_v || m_tready;
  assign occ       = mem_rdata == CELL_OCC;
  assign adv       = occ || !pend_v || ofree;
  assign cur_in    = (cx >= 0) && (int'(cx) < GRID_X) && (cy >= 0) && (int'(cy) < GRID_Y) &&
                     (cz >= 0) && (int'(cz) < GRID_Z);
  assign mem_raddr = cell_idx(cx, cy, cz);

  // Squared distance of the current cell from the sensor; each axis offset equals its step count.
  assign sq_dist = MW'(kx) * MW'(kx) + MW'(ky) * MW'(ky) + MW'(kz) * MW'(kz);
  assign e_xy = earlier(kx, it.ax, ky, it.ay);
  assign e_xz = earlier(kx, it.ax, kz, it.az);
  assign e_yz = earlier(ky, it.ay, kz, it.az);

  always_comb begin
    if (e_xy) begin
      step_c = e_xz ? 3'b001 : 3'b100;
    end else begin
      step_c = e_yz ? 3'b010 : 3'b100;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_raddr;
    mem_wdata = CELL_FREE;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    out_d     = '0;
    last_d    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = CELL_UNKNOWN;
      end
      S_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && q_item.op == OP_MARK) begin
          mem_we    = 1'b1;
          mem_waddr = cell_idx(q_item.ex, q_item.ey, q_item.ez);
          mem_wdata = CELL_OCC;
        end
      end
      S_READ: ;
      S_EVAL: begin
        if (adv && !occ) begin
          mem_we = 1'b1;
          if (pend_v) begin
            load_out = 1'b1;
            out_d    = pend;
          end
        end
      end
      S_DONE: begin
        if (ofree) begin
          load_out = 1'b1;
          out_d    = pend_v ? pend : '0;
          last_d   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pend_v   <= 1'b0;
      nres     <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(NCELL - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            it   <= q_item;
            cx   <= q_item.sx;
            cy   <= q_item.sy;
            cz   <= q_item.sz;
            kx   <= '0;
            ky   <= '0;
            kz   <= '0;
            nres <= '0;
            unique case (q_item.op)
              OP_CAST: state <= S_READ;
              OP_MARK: begin
                pend_v <= 1'b1;
                pend   <= '0;
                state  <= S_DONE;
              end
              default: begin
                pend_v <= 1'b1;
                pend   <= '{freed: 1'b0, x: 4'd0, y: 4'd0, z: 3'd0, oor: 1'b1};
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          if (!cur_in || nres == NW'(MAX_RES)) begin
            state <= S_DONE;
          end else begin
            at_end <= (cx == it.ex) && (cy == it.ey) && (cz == it.ez);
            far    <= sq_dist > it.maxd;
            step   <= step_c;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (adv) begin
            if (!occ) begin
              pend_v <= 1'b1;
              pend   <= '{freed: 1'b1, x: cx[3:0], y: cy[3:0], z: cz[2:0], oor: 1'b0};
              nres   <= nres + 1'b1;
            end
            if (at_end || far || occ) begin
              state <= S_DONE;
            end else begin
              if (step[0]) begin
                cx <= it.neg[0] ? cx - coord_t'(1) : cx + coord_t'(1);
                kx <= kx + 1'b1;
              end
              if (step[1]) begin
                cy <= it.neg[1] ? cy - coord_t'(1) : cy + coord_t'(1);
                ky <= ky + 1'b1;
              end
              if (step[2]) begin
                cz <= it.neg[2] ? cz - coord_t'(1) : cz + coord_t'(1);
                kz <= kz + 1'b1;
              end
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (ofree) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (load_out) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r    <= out_d;
      out_last <= last_d;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {5'b0, out_r.z, out_r.y, out_r.x};
  assign m_tuser  = {out_r.oor, out_r.freed};
  assign m_tlast  = out_last;

  `VRGU_ASSERT_IMPL(a_no_write_in_read, clk, rst, state == S_READ, !mem_we, "write during read")
  `VRGU_ASSERT_IMPL(a_res_cap, clk, rst, 1'b1, nres <= NW'(MAX_RES), "result cap exceeded")
  `VRGU_ASSERT_IMPL(a_idle_no_pend, clk, rst, state == S_IDLE, !pend_v, "stale pending result")
  `VRGU_ASSERT_NEXT(a_clear_no_pop, clk, rst, state == S_CLEAR, !q_pop || state != S_CLEAR,
                    "queue popped during clear")
endmodule

>>> rtl/core/voxel_raycast_grid_update.sv
// Top level of the voxel ray-cast occupancy grid block.
// Depends on vrgu_pkg, vrgu_front, vrgu_fifo and vrgu_back.
//
// This block keeps a GRID_X x GRID_Y x GRID_Z grid of cells, each unknown, free
// or occupied, and updates it from a stream of requests. A mark request sets its
// endpoint cell to occupied and returns one result. A cast request walks a voxel
// traversal from the sensor cell (set through the configuration channel) to its
// endpoint, frees every visited cell that is not occupied and returns one result
// per freed cell, with tlast on the final one; a cast that frees nothing, or that
// starts or ends outside the grid, returns a single result. After reset the grid
// memory is cleared one cell per cycle, all GRID_X*GRID_Y*GRID_Z cells (2048 at
// the default size), and no request is taken until that pass ends. A mark or a
// rejected request is taken from the queue in the idle state and its result is
// loaded in the done state. A cast reads each visited cell from the grid memory
// in the read state, then writes it back and steps in the evaluate state; the
// walk pauses there while a finished result waits for the output register. A
// two-entry queue lets the front accept and classify the next request while
// the walker is busy, and an output register holds a finished result while the
// walker continues.
module voxel_raycast_grid_update #(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // end_x, end_y, end_z, zero fill
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // cell_x, cell_y, cell_z, zero fill
  output logic [1:0]  m_tuser,   // freed_valid, out_of_range
  output logic        m_tlast
);
  import vrgu_pkg::*;

  localparam int QDEPTH = 2;

  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  logic  clearing;
  item_t q_in;
  item_t q_out;

  // Front: sensor registers and classification of each request.
  vrgu_front #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // Queue of classified requests.
  vrgu_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_out),
    .empty(q_empty)
  );

  // Back: grid memory and ray walker.
  vrgu_back #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_out),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .clearing(clearing)
  );

endmodule

>>> dv/voxel_raycast_grid_update_tb.sv
// Self-checking testbench for the voxel ray-cast occupancy grid block.
// Depends on vrgu_pkg for the register indexes and on the block's RTL.
`timescale 1ns / 1ps

module voxel_raycast_grid_update_tb;
  import vrgu_pkg::*;

  // Grid size of the instance under test.
  localparam int GX = 16;
  localparam int GY = 16;
  localparam int GZ = 8;
  localparam int NCELL = GX * GY * GZ;

  // Request kinds as they travel on s_tuser.
  localparam logic KIND_MARK = 1'b0;
  localparam logic KIND_CAST = 1'b1;

  // One expected result, in the fields of a result item.
  typedef struct packed {
    logic       freed;
    logic [3:0] x;
    logic [3:0] y;
    logic [2:0] z;
    logic       oor;
    logic       last;
  } cell_result_t;

  // One row of the directed table. When has_gold is set, gold is the whole
  // expected answer (a single result) and is checked against the predictor too.
  typedef struct {
    logic         kind;
    int           ex;
    int           ey;
    int           ez;
    logic         has_gold;
    cell_result_t gold;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  voxel_raycast_grid_update u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the grid and of the sensor cell.
  logic [1:0]   grid_cells [NCELL];
  int           sensor_pos [3];
  cell_result_t freed_queue [$];
  int           error_count = 0;

  function automatic int sext10(input logic [9:0] v);
    return int'(signed'(v));
  endfunction

  function automatic bit in_grid(input int x, input int y, input int z);
    return x >= 0 && x < GX && y >= 0 && y < GY && z >= 0 && z < GZ;
  endfunction

  // Appends one expected result at the tail of freed_queue.
  function automatic void queue_result(input cell_result_t r);
    freed_queue.insert(freed_queue.size(), r);
  endfunction

  // Strict comparison of crossing times (ka+1)/aa and (kb+1)/ab, done by
  // cross multiplication; a zero delta never crosses.
  function automatic bit crosses_first(input longint ka, input longint aa,
                                       input longint kb, input longint ab);
    if (aa == 0) return 1'b0;
    if (ab == 0) return 1'b1;
    return (ka + 1) * ab < (kb + 1) * aa;
  endfunction

  function automatic cell_result_t make_result(input logic fr, input int x, input int y,
                                               input int z, input logic oor);
    cell_result_t r;
    r.freed = fr;
    r.x     = x[3:0];
    r.y     = y[3:0];
    r.z     = z[2:0];
    r.oor   = oor;
    r.last  = 1'b0;
    return r;
  endfunction

  // Works out the results of one request, updates the predicted grid and
  // appends the results to freed_queue.
  task automatic predict_request(input logic kind, input int ex, input int ey, input int ez);
    int sx, sy, sz, cx, cy, cz, stx, sty, stz, n;
    longint ax, ay, az, kx, ky, kz, maxd, px, py, pz, sq_dist;
    bit occ;
    cell_result_t r;
    int idx;
    sx = sensor_pos[0];
    sy = sensor_pos[1];
    sz = sensor_pos[2];
    n = 0;
    if (kind == KIND_MARK) begin
      if (in_grid(ex, ey, ez)) grid_cells[ex + ey * GX + ez * GX * GY] = CELL_OCC;
      r = make_result(1'b0, 0, 0, 0, !in_grid(ex, ey, ez));
      r.last = 1'b1;
      queue_result(r);
      return;
    end
    if (!in_grid(sx, sy, sz) || !in_grid(ex, ey, ez)) begin
      r = make_result(1'b0, 0, 0, 0, 1'b1);
      r.last = 1'b1;
      queue_result(r);
      return;
    end
    stx = (ex > sx) ? 1 : (ex < sx) ? -1 : 0;
    sty = (ey > sy) ? 1 : (ey < sy) ? -1 : 0;
    stz = (ez > sz) ? 1 : (ez < sz) ? -1 : 0;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    az = (ez > sz) ? ez - sz : sz - ez;
    maxd = ax * ax + ay * ay + az * az;
    kx = 0; ky = 0; kz = 0;
    cx = sx; cy = sy; cz = sz;
    while (in_grid(cx, cy, cz) && n < MAX_RES) begin
      idx = cx + cy * GX + cz * GX * GY;
      px = cx - sx; py = cy - sy; pz = cz - sz;
      sq_dist = px * px + py * py + pz * pz;
      occ = (grid_cells[idx] == CELL_OCC);
      if (!occ) begin
        grid_cells[idx] = CELL_FREE;
        queue_result(make_result(1'b1, cx, cy, cz, 1'b0));
        n++;
      end
      if ((cx == ex && cy == ey && cz == ez) || sq_dist > maxd || occ) break;
      // Ties between x and y go to y; a tie of z with the chosen axis goes to z.
      if (crosses_first(kx, ax, ky, ay)) begin
        if (crosses_first(kx, ax, kz, az)) begin cx += stx; kx++; end
        else begin cz += stz; kz++; end
      end else begin
        if (crosses_first(ky, ay, kz, az)) begin cy += sty; ky++; end
        else begin cz += stz; kz++; end
      end
    end
    if (n == 0) queue_result(make_result(1'b0, 0, 0, 0, 1'b0));
    freed_queue[$].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // Writes one sensor register over the configuration channel. The ready
  // signal is looked at before the edge that takes the request.
  task automatic write_sensor(input logic [1:0] index, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[9:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    sensor_pos[index] = sext10(value[9:0]);
  endtask

  task automatic set_sensor(input int x, input int y, input int z);
    write_sensor(REG_SENSOR_X, x);
    write_sensor(REG_SENSOR_Y, y);
    write_sensor(REG_SENSOR_Z, z);
    cfg_valid <= 1'b0;
  endtask

  // Every request returns at least one result, so once the queue has drained
  // the block is idle; the trailing idle cycles cover the output register.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (freed_queue.size() != 0) @(posedge clk);
    idle_cycles(10);
  endtask

  // Sends one request. The prediction is made at the accepting edge, before
  // any result of this request can appear on the output side. Valid stays up
  // between requests sent with no gap; wait_drained drops it.
  task automatic send_request(input logic kind, input int ex, input int ey, input int ez,
                              input bit random_gap);
    int gap;
    gap = random_gap ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      idle_cycles(gap);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, ez[9:0], ey[9:0], ex[9:0]};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    predict_request(kind, sext10(ex[9:0]), sext10(ey[9:0]), sext10(ez[9:0]));
  endtask

  // Result side: random stalls per result, with stretches of none. Fields are
  // sampled at the falling edge before the accepting rising edge.
  initial begin
    int stall;
    bit no_stall;
    cell_result_t got, want;
    no_stall = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 31) == 0) no_stall = !no_stall;
      stall = no_stall ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        m_tready <= 1'b0;
        idle_cycles(stall);
      end
      m_tready <= 1'b1;
      @(negedge clk);
      while (!m_tvalid) @(negedge clk);
      got.freed = m_tuser[0];
      got.oor   = m_tuser[1];
      got.x     = m_tdata[3:0];
      got.y     = m_tdata[7:4];
      got.z     = m_tdata[10:8];
      got.last  = m_tlast;
      @(posedge clk);
      if (freed_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = freed_queue.pop_front();
        if (got.freed !== want.freed || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z || got.oor !== want.oor || got.last !== want.last)
          report_mismatch($sformatf("got %p expected %p", got, want));
      end
    end
  end

  // Directed table: extremes, both kinds, rejection, nothing freed, same cell,
  // ties and occupied-cell stops. Sensor starts at the origin.
  dir_row_t dir_table [$];

  function automatic dir_row_t row(input logic kind, input int ex, input int ey,
                                   input int ez, input bit gold_set, input logic oor);
    dir_row_t d;
    d.kind = kind;
    d.ex = ex; d.ey = ey; d.ez = ez;
    d.has_gold = gold_set;
    d.gold = make_result(1'b0, 0, 0, 0, oor);
    d.gold.last = 1'b1;
    return d;
  endfunction

  initial begin
    int k, mode;
    int ex, ey, ez;
    logic kind;
    cell_result_t want;
    sensor_pos[0] = 0; sensor_pos[1] = 0; sensor_pos[2] = 0;
    for (int i = 0; i < NCELL; i++) grid_cells[i] = CELL_UNKNOWN;
    idle_cycles(10);
    rst <= 1'b0;

    dir_table = {dir_table, row(KIND_MARK, 511, 0, 0, 1, 1'b1)};
    dir_table = {dir_table, row(KIND_MARK, -512, -512, -512, 1, 1'b1)};
    dir_table = {dir_table, row(KIND_MARK, 0, 0, 511, 1, 1'b1)};
    dir_table = {dir_table, row(KIND_CAST, -1, 0, 0, 1, 1'b1)};
    dir_table = {dir_table, row(KIND_CAST, 16, 0, 0, 1, 1'b1)};
    dir_table = {dir_table, row(KIND_CAST, 0, 0, 0, 0, 1'b0)};      // same cell
    dir_table = {dir_table, row(KIND_CAST, 15, 15, 7, 0, 1'b0)};
    dir_table = {dir_table, row(KIND_CAST, 5, 5, 0, 0, 1'b0)};      // x/y ties
    dir_table = {dir_table, row(KIND_CAST, 4, 0, 4, 0, 1'b0)};      // z ties
    dir_table = {dir_table, row(KIND_MARK, 3, 0, 0, 1, 1'b0)};
    dir_table = {dir_table, row(KIND_CAST, 10, 0, 0, 0, 1'b0)};     // stops at occupied
    dir_table = {dir_table, row(KIND_MARK, 0, 0, 0, 1, 1'b0)};
    dir_table = {dir_table, row(KIND_CAST, 6, 6, 6, 1, 1'b0)};      // nothing freed
    dir_table = {dir_table, row(KIND_MARK, 15, 15, 7, 1, 1'b0)};
    dir_table = {dir_table, row(KIND_CAST, 15, 0, 7, 0, 1'b0)};

    @(posedge clk);
    while (!s_tready && !cfg_ready) @(posedge clk);
    set_sensor(0, 0, 0);
    foreach (dir_table[i]) begin
      send_request(dir_table[i].kind, dir_table[i].ex, dir_table[i].ey, dir_table[i].ez, 1);
      if (dir_table[i].has_gold) begin
        want = freed_queue[$];
        if (want !== dir_table[i].gold)
          report_mismatch($sformatf("table row %0d predicts %p", i, want));
      end
    end
    wait_drained();

    // Sensor at the far corner, then out of range, then back inside.
    set_sensor(15, 15, 7);
    send_request(KIND_CAST, 0, 0, 0, 1);
    send_request(KIND_CAST, 0, 15, 0, 1);
    wait_drained();
    set_sensor(-512, 511, -1);
    send_request(KIND_CAST, 1, 1, 1, 1);
    send_request(KIND_MARK, 1, 1, 1, 1);
    wait_drained();

    // Random part: mostly in-grid casts with a sprinkling of marks and
    // out-of-range noise; the sensor moves between phases.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) set_sensor($urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023));
      else set_sensor($urandom_range(0, GX - 1), $urandom_range(0, GY - 1),
                      $urandom_range(0, GZ - 1));
      for (k = 0; k < 18; k++) begin
        mode = $urandom_range(0, 9);
        kind = (mode < 7) ? KIND_CAST : KIND_MARK;
        if (mode == 9) begin
          ex = $urandom_range(0, 1023); ey = $urandom_range(0, 1023);
          ez = $urandom_range(0, 1023);
        end else begin
          ex = $urandom_range(0, GX - 1); ey = $urandom_range(0, GY - 1);
          ez = $urandom_range(0, GZ - 1);
        end
        send_request(kind, ex, ey, ez, (phase != 2));
        // Hold off until the block has returned everything owed so far.
        if (k == 10) wait_drained();
      end
      wait_drained();
    end
    idle_cycles(200);
    if (error_count == 0 && freed_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
